@@ design/spm_pkg.sv @@
package spm_pkg;

    localparam int CNT_W                = 7;
    localparam int SEG_FIELD_W          = 6;
    localparam int ESIZE_W              = 16;
    localparam int OPCODE_W             = 3;
    localparam int CFG_IDX_W            = 1;
    localparam int CFG_DATA_W           = 16;
    localparam int RESULT_CAP           = 32;
    localparam int DEFAULT_MAX_SEGMENTS = 64;
    localparam int ESIZE_RESET          = 1;

    localparam logic [OPCODE_W-1:0] OP_MARK_WRITTEN = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_MARK_ERASED  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LIST_MISSING = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LIST_PRESENT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE    = 1'd1;

    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic [SEG_FIELD_W-1:0] segment_index;
    } t_cmd;

    typedef struct packed {
        logic                   region_valid;
        logic [SEG_FIELD_W-1:0] region_start;
        logic [SEG_FIELD_W-1:0] region_end;
        logic [ESIZE_W-1:0]     region_element_size;
        logic [CNT_W-1:0]       present_count;
        logic [CNT_W-1:0]       absent_count;
        logic                   bad_index;
        logic                   last;
    } t_res;

endpackage

@@ design/spm_cmd_if.sv @@
interface spm_cmd_if
    import spm_pkg::*;
;
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/spm_res_if.sv @@
interface spm_res_if
    import spm_pkg::*;
;
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/segment_presence_map.sv @@
// Segment presence map.
// Commands arrive on i_cmd: mark a segment written or erased, clear all bits, or list
// the runs of missing or present segments. Results leave on o_res, one transfer per
// run (at most 32) for a list command that finds a run and exactly one transfer
// otherwise; the last transfer of a command has last set. Every result carries the
// present and absent counts.
// A mark, clear or unknown command goes to S_FINISH, which loads its result into the
// output register once that register is free; only then does the block return to
// idle and accept the next command. A list command walks the presence bits with a
// single bit reader and run tracker, one segment per cycle unless a finished run must
// wait for the output register; i_cmd.ready is low until the final result is in the
// output register.
// Writing segments_in_use through the configuration port starts a recount of the
// present bits, during which no command is accepted. A run found while the
// previous one still waits is held until the output register is free, so a
// stalled receiver pauses the scan and loses nothing.
// Reset clears all presence bits and the counts, sets segments_in_use to MAX_SEGMENTS
// (at most 64) and element_size to 1, and leaves the block ready with no result pending.
module segment_presence_map
    import spm_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEFAULT_MAX_SEGMENTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    spm_cmd_if.sink               i_cmd,
    spm_res_if.source             o_res,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int FIELD_SPAN = 2 ** SEG_FIELD_W;
    localparam int STORE      = (MAX_SEGMENTS < FIELD_SPAN) ? MAX_SEGMENTS : FIELD_SPAN;
    localparam int IDX_W      = $clog2(STORE);
    localparam int RUN_W      = $clog2(RESULT_CAP);
    localparam logic [CNT_W-1:0] SEG_RESET = CNT_W'(STORE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_COUNT
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_seg;
    logic [ESIZE_W-1:0]     r_esize;
    logic [STORE-1:0]       r_bits;
    logic [CNT_W-1:0]       r_present;
    logic [CNT_W-1:0]       r_idx;
    logic                   r_want;
    logic                   r_in_run;
    logic [SEG_FIELD_W-1:0] r_start;
    logic                   r_pend_v;
    logic [SEG_FIELD_W-1:0] r_pend_s;
    logic [SEG_FIELD_W-1:0] r_pend_e;
    logic [RUN_W-1:0]       r_nruns;
    logic                   r_bad;
    logic                   r_o_valid;
    t_res                   r_o_data;

    logic [CNT_W-1:0]       n_seg;
    logic                   scan_bit;
    logic                   mark_old;
    logic                   in_range;
    logic                   cmd_fire;
    logic                   slot_free;
    logic                   term;
    logic                   hit;
    logic                   run_end;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o_data;

    always_comb begin
        if (i_cfg_wdata[CNT_W-1:0] == '0) begin
            n_seg = CNT_W'(1);
        end else if (int'(i_cfg_wdata[CNT_W-1:0]) > MAX_SEGMENTS) begin
            n_seg = CNT_W'(MAX_SEGMENTS);
        end else begin
            n_seg = i_cfg_wdata[CNT_W-1:0];
        end
    end

    always_comb begin
        scan_bit  = (int'(r_idx) < STORE) ? r_bits[r_idx[IDX_W-1:0]] : 1'b0;
        in_range  = ({1'b0, i_cmd.data.segment_index} < r_seg);
        mark_old  = r_bits[i_cmd.data.segment_index[IDX_W-1:0]];
        cmd_fire  = i_cmd.valid && (r_state == S_IDLE);
        slot_free = !r_o_valid || o_res.ready;
        term      = (r_idx == r_seg);
        hit       = !term && (scan_bit == r_want);
        run_end   = r_in_run && (term || (scan_bit != r_want));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seg     <= SEG_RESET;
            r_esize   <= ESIZE_W'(ESIZE_RESET);
            r_bits    <= '0;
            r_present <= '0;
            r_idx     <= '0;
            r_in_run  <= 1'b0;
            r_pend_v  <= 1'b0;
            r_nruns   <= '0;
            r_bad     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_bad    <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_in_run <= 1'b0;
                        r_idx    <= '0;
                        r_nruns  <= '0;
                        r_want   <= (i_cmd.data.opcode == OP_LIST_PRESENT);
                        r_state  <= S_FINISH;
                        case (i_cmd.data.opcode)
                            OP_MARK_WRITTEN, OP_MARK_ERASED: begin
                                if (in_range) begin
                                    r_bits[i_cmd.data.segment_index[IDX_W-1:0]] <=
                                        (i_cmd.data.opcode == OP_MARK_WRITTEN);
                                    if ((i_cmd.data.opcode == OP_MARK_WRITTEN) && !mark_old) begin
                                        r_present <= r_present + CNT_W'(1);
                                    end else if ((i_cmd.data.opcode == OP_MARK_ERASED) &&
                                                 mark_old) begin
                                        r_present <= r_present - CNT_W'(1);
                                    end
                                end else begin
                                    r_bad <= 1'b1;
                                end
                            end
                            OP_CLEAR_ALL: begin
                                r_bits    <= '0;
                                r_present <= '0;
                            end
                            OP_LIST_MISSING, OP_LIST_PRESENT: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (run_end) begin
                        if (!r_pend_v || slot_free) begin
                            if (r_pend_v) begin
                                r_o_valid <= 1'b1;
                                r_o_data  <= '{region_valid: 1'b1,
                                               region_start: r_pend_s,
                                               region_end: r_pend_e,
                                               region_element_size: r_esize,
                                               present_count: r_present,
                                               absent_count: r_seg - r_present,
                                               bad_index: 1'b0,
                                               last: 1'b0};
                            end
                            r_pend_v <= 1'b1;
                            r_pend_s <= r_start;
                            r_pend_e <= SEG_FIELD_W'(r_idx - CNT_W'(1));
                            r_in_run <= 1'b0;
                            r_nruns  <= r_nruns + RUN_W'(1);
                            if (term || (r_nruns == RUN_W'(RESULT_CAP - 1))) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_idx <= r_idx + CNT_W'(1);
                            end
                        end
                    end else if (term) begin
                        r_state <= S_FINISH;
                    end else begin
                        if (hit && !r_in_run) begin
                            r_in_run <= 1'b1;
                            r_start  <= r_idx[SEG_FIELD_W-1:0];
                        end
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= '{region_valid: r_pend_v,
                                       region_start: r_pend_v ? r_pend_s : '0,
                                       region_end: r_pend_v ? r_pend_e : '0,
                                       region_element_size: r_pend_v ? r_esize : '0,
                                       present_count: r_present,
                                       absent_count: r_seg - r_present,
                                       bad_index: r_bad,
                                       last: 1'b1};
                        r_pend_v  <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                S_COUNT: begin
                    if (term) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_present <= r_present + CNT_W'(scan_bit);
                        r_idx     <= r_idx + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SEGMENTS_IN_USE: begin
                        r_seg     <= n_seg;
                        r_idx     <= '0;
                        r_present <= '0;
                        r_state   <= S_COUNT;
                        for (int j = 0; j < STORE; j++) begin
                            if (j >= int'(n_seg)) begin
                                r_bits[j] <= 1'b0;
                            end
                        end
                    end
                    CFG_ELEMENT_SIZE: begin
                        r_esize <= i_cfg_wdata[ESIZE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_present_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_present <= r_seg)
        else $error("present count exceeds segments in use");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_seg))
        else $error("scan index ran past the segments in use");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && !i_cfg_wr_en) |=> !i_cmd.ready)
        else $error("new command taken before the previous one finished");

    a_not_last_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_data.last) |-> r_o_data.region_valid)
        else $error("intermediate result carries no run");

    a_pending_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_pend_e >= r_pend_s))
        else $error("held run ends before it starts");

endmodule

@@ dv/tb.sv @@
module tb;
    import spm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEGMENTS   = DEFAULT_MAX_SEGMENTS;
    localparam int unsigned HOLD_LONG  = 400;
    localparam int unsigned SETTLE     = DEFAULT_MAX_SEGMENTS + 4;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    class presence_tracker;
        bit [SEGMENTS-1:0]  bits;
        int unsigned        in_use;
        logic [ESIZE_W-1:0] element_size;
        t_res               expected_regions[$];
        int unsigned        mismatch_count;

        function new();
            bits = '0;
            in_use = SEGMENTS;
            element_size = ESIZE_W'(ESIZE_RESET);
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return expected_regions.size();
        endfunction

        task flag_mismatch(input string what, input int unsigned got, input int unsigned want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatch_count++;
        endtask

        function void configure(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_SEGMENTS_IN_USE) begin
                in_use = value[CNT_W-1:0];
                if (in_use < 1)
                    in_use = 1;
                if (in_use > SEGMENTS)
                    in_use = SEGMENTS;
                for (int i = in_use; i < SEGMENTS; i++)
                    bits[i] = 1'b0;
            end else begin
                element_size = value[ESIZE_W-1:0];
            end
        endfunction

        function t_res region(input bit run, input int unsigned first, input int unsigned final_idx,
                              input int unsigned present, input bit bad);
            t_res r;
            r = '0;
            r.region_valid = run;
            if (run) begin
                r.region_start = SEG_FIELD_W'(first);
                r.region_end = SEG_FIELD_W'(final_idx);
                r.region_element_size = element_size;
            end
            r.present_count = CNT_W'(present);
            r.absent_count = CNT_W'(in_use - present);
            r.bad_index = bad;
            return r;
        endfunction

        function void apply_command(input t_cmd c);
            int unsigned present;
            int unsigned first;
            int unsigned runs;
            bit bad;
            bit want;
            t_res r;
            bad = 1'b0;
            present = 0;
            first = 0;
            runs = 0;
            case (c.opcode)
                OP_MARK_WRITTEN, OP_MARK_ERASED: begin
                    if (c.segment_index < in_use)
                        bits[c.segment_index] = (c.opcode == OP_MARK_WRITTEN);
                    else
                        bad = 1'b1;
                end
                OP_CLEAR_ALL: bits = '0;
                default: ;
            endcase
            for (int i = 0; i < in_use; i++)
                present += bits[i];
            if (c.opcode == OP_LIST_MISSING || c.opcode == OP_LIST_PRESENT) begin
                want = (c.opcode == OP_LIST_PRESENT);
                for (int i = 0; i < in_use && runs < RESULT_CAP; i++) begin
                    if (bits[i] != want)
                        continue;
                    if (i == 0 || bits[i-1] != want)
                        first = i;
                    if (i + 1 >= in_use || bits[i+1] != want) begin
                        expected_regions.push_back(region(1'b1, first, i, present, 1'b0));
                        runs++;
                    end
                end
            end
            if (runs == 0)
                expected_regions.push_back(region(1'b0, 0, 0, present, bad));
            r = expected_regions.pop_back();
            r.last = 1'b1;
            expected_regions.push_back(r);
        endfunction

        task check_field(input string what, input int unsigned got, input int unsigned want);
            if (got != want)
                flag_mismatch(what, got, want);
        endtask

        task compare_region(input t_res got);
            t_res want;
            if (expected_regions.size() == 0) begin
                flag_mismatch("result transfer with nothing expected", 0, 0);
                return;
            end
            want = expected_regions.pop_front();
            check_field("region_valid", got.region_valid, want.region_valid);
            check_field("region_start", got.region_start, want.region_start);
            check_field("region_end", got.region_end, want.region_end);
            check_field("region_element_size", got.region_element_size, want.region_element_size);
            check_field("present_count", got.present_count, want.present_count);
            check_field("absent_count", got.absent_count, want.absent_count);
            check_field("bad_index", got.bad_index, want.bad_index);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    spm_cmd_if cmd_if ();
    spm_res_if res_if ();

    presence_tracker tracker = new();

    bit send_quiet;
    bit recv_quiet;
    bit hold_request;

    segment_presence_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // A long hold-off is requested by the stimulus and counted out here.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_LONG) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap(recv_quiet);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.compare_region(res_if.data);
    end

    task automatic send_command(input logic [OPCODE_W-1:0] op,
                                input logic [SEG_FIELD_W-1:0] idx);
        int unsigned gap;
        t_cmd c;
        gap = pick_gap(send_quiet);
        c.opcode = op;
        c.segment_index = idx;
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        do @(posedge i_clk); while (!cmd_if.ready);
        tracker.apply_command(c);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Writing segments_in_use starts a recount, so every write is followed by a settle time.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        tracker.configure(idx, value);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned sent;
        int unsigned marks;
        int unsigned bias;
        int unsigned span;
        sent = 0;
        span = tracker.in_use;
        while (sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                marks = $urandom_range(1, 10);
                bias = $urandom_range(1, 9);
                repeat (marks) begin
                    send_command(($urandom_range(0, 9) < bias) ? OP_MARK_WRITTEN : OP_MARK_ERASED,
                                 ($urandom_range(0, 19) < 17)
                                     ? SEG_FIELD_W'($urandom_range(0, span - 1))
                                     : SEG_FIELD_W'($urandom_range(0, 63)));
                end
                sent += marks + 1;
                if ($urandom_range(0, 9) == 0) begin
                    send_command(OP_CLEAR_ALL, SEG_FIELD_W'($urandom));
                    sent++;
                end
                send_command($urandom_range(0, 1) ? OP_LIST_PRESENT : OP_LIST_MISSING,
                             SEG_FIELD_W'($urandom));
            end else begin
                send_command(OPCODE_W'($urandom_range(0, 7)), SEG_FIELD_W'($urandom_range(0, 63)));
                sent++;
            end
        end
    endtask

    // Every even segment written gives the largest number of runs, and the receiver
    // holds off while the lists are offered so the block backs up into its input.
    task automatic alternating_burst();
        send_command(OP_CLEAR_ALL, '0);
        for (int i = 0; i < SEGMENTS; i += 2)
            send_command(OP_MARK_WRITTEN, SEG_FIELD_W'(i));
        hold_request = 1'b1;
        send_command(OP_LIST_PRESENT, '0);
        send_command(OP_LIST_MISSING, '0);
        send_command(OP_MARK_ERASED, SEG_FIELD_W'(SEGMENTS - 2));
        send_command(OP_LIST_PRESENT, '1);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] seg_value;
        logic [CFG_DATA_W-1:0] size_value;
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        hold_request = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(OP_LIST_MISSING, '0);
        send_command(OP_LIST_PRESENT, '1);
        send_command(OP_MARK_WRITTEN, 6'd0);
        send_command(OP_MARK_WRITTEN, 6'd63);
        send_command(OP_LIST_PRESENT, '0);
        send_command(OP_LIST_MISSING, '0);
        send_command(OP_MARK_ERASED, 6'd63);
        send_command(OP_MARK_ERASED, 6'd5);
        send_command(OP_UNUSED_LO, 6'd63);
        send_command(OP_UNUSED_HI, 6'd0);
        send_command(OP_CLEAR_ALL, '1);
        send_command(OP_LIST_PRESENT, '0);
        send_command(OP_LIST_MISSING, '0);
        wait_idle();

        write_register(CFG_ELEMENT_SIZE, 16'd0);
        write_register(CFG_SEGMENTS_IN_USE, 16'd0);
        send_command(OP_MARK_WRITTEN, 6'd0);
        send_command(OP_MARK_WRITTEN, 6'd1);
        send_command(OP_MARK_ERASED, 6'd63);
        send_command(OP_LIST_PRESENT, '0);
        send_command(OP_LIST_MISSING, '0);
        send_command(OP_MARK_ERASED, 6'd0);
        send_command(OP_LIST_MISSING, '0);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            size_value = CFG_DATA_W'($urandom);
            case (p)
                0: begin
                    seg_value = 16'hFFFF;
                    size_value = 16'hFFFF;
                end
                1: seg_value = 16'd2;
                2: begin
                    seg_value = CFG_DATA_W'(SEGMENTS);
                    size_value = 16'd1;
                end
                3: seg_value = CFG_DATA_W'($urandom_range(1, SEGMENTS));
                4: seg_value = 16'd1;
                default: seg_value = CFG_DATA_W'($urandom_range(3, SEGMENTS - 1));
            endcase
            send_quiet = (p == 1 || p == 4);
            recv_quiet = (p == 1 || p == 3);
            write_register(CFG_ELEMENT_SIZE, size_value);
            write_register(CFG_SEGMENTS_IN_USE, seg_value);
            if (p == 2)
                alternating_burst();
            random_phase(30);
            wait_idle();
        end

        repeat (SETTLE) @(negedge i_clk);
        if (tracker.pending() != 0)
            tracker.flag_mismatch("results never delivered", 0, tracker.pending());
        if (tracker.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ segment_presence_map.f @@
design/spm_pkg.sv
design/spm_cmd_if.sv
design/spm_res_if.sv
design/segment_presence_map.sv
dv/tb.sv
